// File: src/ule_pkg.sv
// Package for the unsorted list engine: sizes, field types, action codes,
// sequencer states and the slot-to-RAM address mapping. No dependencies.

package ule_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int ACTION_W    = 3;
	localparam int DATA_W      = 32;
	localparam int COUNT_OUT_W = 5;

	typedef logic [ACTION_W-1:0]    action_bits_t;
	typedef logic [DATA_W-1:0]      data_t;
	typedef logic [COUNT_OUT_W-1:0] count_out_t;
	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD      = 3'd0,
		ACT_DELETE   = 3'd1,
		ACT_CONTAINS = 3'd2,
		ACT_CLEAR    = 3'd3,
		ACT_RESET    = 3'd4,
		ACT_NEXT     = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic   hit;
		logic   accepted;
		value_t value_out;
		logic   at_end;
		cnt_t   entry_count;
	} rsp_t;

	typedef struct packed {
		logic   we;
		idx_t   waddr;
		value_t wdata;
		logic   re;
		idx_t   raddr;
	} ram_ctl_t;

	// Map list slot k (head is slot 0) onto a RAM address of the ring.
	function automatic idx_t slot_addr(input idx_t head, input cnt_t k);
		logic [IDX_W:0] s;
		s = {1'b0, head} + {1'b0, k[IDX_W-1:0]};
		if (s >= (IDX_W + 1)'(CAPACITY)) begin
			s = s - (IDX_W + 1)'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// File: src/ule_req_if.sv
// Request channel of the unsorted list engine: valid/ready plus action and value.
// Depends on ule_pkg.

interface ule_req_if;
	logic                 valid;
	logic                 ready;
	ule_pkg::action_bits_t action;
	ule_pkg::data_t       value_in;

	modport source (output valid, output action, output value_in, input ready);
	modport sink   (input valid, input action, input value_in, output ready);
endinterface

// File: src/ule_rsp_if.sv
// Result channel of the unsorted list engine: valid/ready plus result fields.
// Depends on ule_pkg.

interface ule_rsp_if;
	logic                valid;
	logic                ready;
	logic                hit;
	logic                accepted;
	ule_pkg::data_t      value_out;
	logic                at_end;
	ule_pkg::count_out_t entry_count;

	modport source (output valid, output hit, output accepted, output value_out,
		output at_end, output entry_count, input ready);
	modport sink   (input valid, input hit, input accepted, input value_out,
		input at_end, input entry_count, output ready);
endinterface

// File: src/unsorted_list_engine.sv
// Top level of the unsorted list engine: sequencer, ring pointers and result register.
// Depends on ule_pkg, ule_req_if, ule_rsp_if and ule_ram.
//
// channel  dir  handshake     payload
// req      in   valid/ready   action, value_in
// rsp      out  valid/ready   hit, accepted, value_out, at_end, entry_count
//
// Entries sit in a ring in one RAM; add moves the head pointer back, so it
// passes only EXEC and DONE, as do clear, cursor reset and unused codes; read next
// adds READ. Contains and delete share one comparator and the RAM read port:
// SCAN and CMP per entry scanned, and delete SHIFT_RD and SHIFT_WR per later entry.
// Reset clears count, cursor, head and result valid; RAM contents need no reset.
// A stalled result holds in its register while the next request is taken.

module unsorted_list_engine (
	input logic       clk,
	input logic       arst_n,
	ule_req_if.sink   req,
	ule_rsp_if.source rsp
);

	ule_pkg::state_t   state_q, state_nxt;
	ule_pkg::action_t  act_q;
	ule_pkg::value_t   key_q;
	ule_pkg::idx_t     head_q;
	ule_pkg::cnt_t     count_q;
	ule_pkg::cnt_t     cursor_q;
	ule_pkg::cnt_t     k_q;
	ule_pkg::cnt_t     pos_q;
	ule_pkg::rsp_t     work_q;
	ule_pkg::rsp_t     out_q;
	logic              out_valid_q;

	ule_pkg::ram_ctl_t ram_ctl;
	ule_pkg::value_t   ram_rdata;
	ule_pkg::idx_t     head_dec;
	ule_pkg::cnt_t     k_inc;
	logic              req_acc;
	logic              list_full;
	logic              match;
	logic              out_load;

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == ule_pkg::ST_IDLE);
	assign list_full = (count_q == ule_pkg::cnt_t'(ule_pkg::CAPACITY));
	assign match     = (ram_rdata == key_q);
	assign k_inc     = k_q + 1'b1;
	assign head_dec  = (head_q == '0) ? ule_pkg::idx_t'(ule_pkg::CAPACITY - 1)
		: head_q - 1'b1;
	assign out_load  = (state_q == ule_pkg::ST_DONE) && (!out_valid_q || rsp.ready);

	ule_ram #(
		.WIDTH (ule_pkg::VALUE_WIDTH),
		.DEPTH (ule_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_ctl.we),
		.waddr (ram_ctl.waddr),
		.wdata (ram_ctl.wdata),
		.re    (ram_ctl.re),
		.raddr (ram_ctl.raddr),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ule_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_nxt = ule_pkg::ST_EXEC;
				end
			end
			ule_pkg::ST_EXEC: begin
				case (act_q)
					ule_pkg::ACT_DELETE,
					ule_pkg::ACT_CONTAINS: state_nxt = ule_pkg::ST_SCAN;
					ule_pkg::ACT_NEXT: begin
						state_nxt = (cursor_q < count_q) ? ule_pkg::ST_READ
							: ule_pkg::ST_DONE;
					end
					default: state_nxt = ule_pkg::ST_DONE;
				endcase
			end
			ule_pkg::ST_SCAN: begin
				state_nxt = (k_q == count_q) ? ule_pkg::ST_DONE : ule_pkg::ST_CMP;
			end
			ule_pkg::ST_CMP: begin
				if (!match) begin
					state_nxt = ule_pkg::ST_SCAN;
				end else if (act_q == ule_pkg::ACT_DELETE) begin
					state_nxt = ule_pkg::ST_SHIFT_RD;
				end else begin
					state_nxt = ule_pkg::ST_DONE;
				end
			end
			ule_pkg::ST_SHIFT_RD: begin
				state_nxt = (k_inc == count_q) ? ule_pkg::ST_DONE : ule_pkg::ST_SHIFT_WR;
			end
			ule_pkg::ST_SHIFT_WR: state_nxt = ule_pkg::ST_SHIFT_RD;
			ule_pkg::ST_READ:     state_nxt = ule_pkg::ST_DONE;
			ule_pkg::ST_DONE: begin
				if (out_load) begin
					state_nxt = ule_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ule_pkg::ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		ram_ctl.we    = 1'b0;
		ram_ctl.waddr = ule_pkg::slot_addr(head_q, k_q);
		ram_ctl.wdata = ram_rdata;
		ram_ctl.re    = 1'b0;
		ram_ctl.raddr = ule_pkg::slot_addr(head_q, k_q);
		case (state_q)
			ule_pkg::ST_EXEC: begin
				if (act_q == ule_pkg::ACT_ADD && !list_full) begin
					ram_ctl.we    = 1'b1;
					ram_ctl.waddr = head_dec;
					ram_ctl.wdata = key_q;
				end
				if (act_q == ule_pkg::ACT_NEXT && cursor_q < count_q) begin
					ram_ctl.re    = 1'b1;
					ram_ctl.raddr = ule_pkg::slot_addr(head_q, cursor_q);
				end
			end
			ule_pkg::ST_SCAN: begin
				ram_ctl.re = (k_q != count_q);
			end
			ule_pkg::ST_SHIFT_RD: begin
				ram_ctl.re    = (k_inc != count_q);
				ram_ctl.raddr = ule_pkg::slot_addr(head_q, k_inc);
			end
			ule_pkg::ST_SHIFT_WR: begin
				ram_ctl.we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ule_pkg::ST_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ule_pkg::ST_EXEC: begin
					case (act_q)
						ule_pkg::ACT_ADD: begin
							if (!list_full) begin
								head_q   <= head_dec;
								count_q  <= count_q + 1'b1;
								cursor_q <= cursor_q + 1'b1;
							end
						end
						ule_pkg::ACT_CLEAR: begin
							count_q  <= '0;
							cursor_q <= '0;
						end
						ule_pkg::ACT_RESET: cursor_q <= '0;
						default: begin
						end
					endcase
				end
				ule_pkg::ST_SHIFT_RD: begin
					if (k_inc == count_q) begin
						count_q <= count_q - 1'b1;
						if (cursor_q > pos_q) begin
							cursor_q <= cursor_q - 1'b1;
						end
					end
				end
				ule_pkg::ST_READ: cursor_q <= cursor_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Working registers of the transaction in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ule_pkg::ST_IDLE: begin
				if (req_acc) begin
					act_q              <= ule_pkg::action_t'(req.action);
					key_q              <= req.value_in[ule_pkg::VALUE_WIDTH-1:0];
					k_q                <= '0;
					pos_q              <= '0;
					work_q.hit         <= 1'b0;
					work_q.accepted    <= 1'b1;
					work_q.value_out   <= '0;
					work_q.at_end      <= 1'b0;
				end
			end
			ule_pkg::ST_EXEC: begin
				if (act_q == ule_pkg::ACT_ADD && list_full) begin
					work_q.accepted <= 1'b0;
				end
				if (act_q == ule_pkg::ACT_NEXT && !(cursor_q < count_q)) begin
					work_q.at_end <= 1'b1;
				end
			end
			ule_pkg::ST_CMP: begin
				if (match) begin
					work_q.hit <= 1'b1;
					pos_q      <= k_q;
				end else begin
					k_q <= k_inc;
				end
			end
			ule_pkg::ST_SHIFT_WR: k_q <= k_inc;
			ule_pkg::ST_READ:     work_q.value_out <= ram_rdata;
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Take the count as it stands after the transaction
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= '{hit: work_q.hit, accepted: work_q.accepted,
				value_out: work_q.value_out, at_end: work_q.at_end,
				entry_count: count_q};
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_q.hit;
	assign rsp.accepted    = out_q.accepted;
	assign rsp.value_out   = ule_pkg::data_t'(out_q.value_out);
	assign rsp.at_end      = out_q.at_end;
	assign rsp.entry_count = ule_pkg::count_out_t'(out_q.entry_count);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ule_pkg::cnt_t'(ule_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("cursor beyond end of list");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ule_pkg::ST_IDLE) |-> !ram_ctl.we)
		else $error("RAM write while idle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req.ready)
		else $error("request taken while busy");

endmodule

// File: src/ule_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module ule_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
